### design/text_console_writer_assert.svh
// ----------------------------------------------------------------------------
// text_console_writer_assert.svh
// Assertion macros used by the console writer top level.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text_console_writer: next-cycle check failed");

// Expression must never be true.
`define TCW_ASSERT_NEVER(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("text_console_writer: forbidden condition seen");

`endif

### design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Payload types, operation codes and controller/datapath links.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_SET   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  localparam logic [7:0] CH_NL = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] CH_BS = 8'd8;
  localparam logic [7:0] CH_SP = 8'd32;

  localparam logic CFG_TEXT_COLOR   = 1'b0;
  localparam logic CFG_CURSOR_SHOWN = 1'b1;

  localparam logic [7:0] COLOR_RESET = 8'd15;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] char_code;
    logic [4:0] row;
    logic [6:0] col;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_char;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        position_write;
    logic [10:0] position_value;
    logic        scrolled;
  } out_t;

  typedef struct packed {
    logic load;
    logic fill;
    logic exec;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic need_fill;
    logic fill_last;
    logic out_free;
  } status_t;

endpackage

### design/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode character screen with cursor: write, read, set cursor, clear.
// ----------------------------------------------------------------------------
// An item passes through accept, execute with the memory read, and result
// load, and the result load waits until the output register is free. A
// character or backspace that lands in a row that has not been written since
// reset, the last clear or the scroll that brought it to the bottom first
// has that row blanked one cell per cycle through the single screen-memory
// port, then the execute step is tried again. Scroll and clear cost no sweep:
// rows form a ring with a per-row valid bit, and a row that is not valid
// reads as spaces. No clearing pass follows reset. One item is in flight at
// a time; the result register lets the next item be accepted while a result
// waits.
// ----------------------------------------------------------------------------
`include "text_console_writer_assert.svh"

module text_console_writer #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  tcw_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tcw_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;

  tcw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  tcw_dp #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  `TCW_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  `TCW_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid)
  `TCW_ASSERT_NEVER(a_fill_exec_excl, cmd.fill && cmd.exec)

endmodule

### design/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer: accept, blank a fresh row when needed, execute, hand off result.
// ----------------------------------------------------------------------------
module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tcw_pkg::status_t  status,
  output tcw_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_FILL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // target row still stale: blank it before touching a cell
        if (status.need_fill) begin
          state_nxt = ST_FILL;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (status.fill_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### design/tcw_dp.sv
// ----------------------------------------------------------------------------
// tcw_dp
// Screen memory as a ring of rows, cursor, row-valid bits and result register.
// ----------------------------------------------------------------------------
module tcw_dp #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::in_t      in_data,
  input  logic              out_ready,
  output logic              out_valid,
  output tcw_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data,
  input  tcw_pkg::cmd_t     cmd,
  output tcw_pkg::status_t  status
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int AW = $clog2(ROWS * COLS);

  logic [15:0]    mem [ROWS*COLS];

  tcw_pkg::in_t   item_r;
  logic [RW-1:0]  cur_row_r, cur_row_nxt;
  logic [CW-1:0]  cur_col_r, cur_col_nxt;
  logic [RW-1:0]  top_r, top_nxt;
  logic [ROWS-1:0] row_vld_r, row_vld_nxt;
  logic [CW-1:0]  fill_cnt_r, fill_cnt_nxt;
  logic [7:0]     color_r;
  logic           shown_r;
  logic [7:0]     rd_data_r;
  logic           read_mem_r, read_blank_r, pw_r, sc_r;
  logic           out_valid_r, out_valid_nxt;
  tcw_pkg::out_t  out_data_r, out_data_nxt;

  logic           is_wr, is_rd;
  logic           is_nl, is_cr, is_bs, bs_nop, cell_write;
  logic           row_ok, col_ok, read_ok;
  logic [CW-1:0]  cell_col, lcol;
  logic [RW-1:0]  lrow, phys_row;
  logic [RW:0]    phys_sum;
  logic [AW-1:0]  addr, lin_idx;
  logic           row_ready, wr_en, rd_en;
  logic [15:0]    wr_data;
  logic [CW:0]    col_inc;
  logic           col_wrap, row_adv, scroll;
  logic [7:0]     read_char;

  // ---------------------------------------------------------------- decode
  always_comb begin
    is_wr      = item_r.func == tcw_pkg::FUNC_WRITE;
    is_rd      = item_r.func == tcw_pkg::FUNC_READ;
    is_nl      = is_wr && item_r.char_code == tcw_pkg::CH_NL;
    is_cr      = is_wr && item_r.char_code == tcw_pkg::CH_CR;
    is_bs      = is_wr && item_r.char_code == tcw_pkg::CH_BS;
    bs_nop     = is_bs && cur_col_r == '0;
    cell_write = is_wr && !is_nl && !is_cr && !bs_nop;
    cell_col   = is_bs ? cur_col_r - 1'b1 : cur_col_r;
    row_ok     = int'(item_r.row) < ROWS;
    col_ok     = int'(item_r.col) < COLS;
    read_ok    = row_ok && col_ok;

    // map logical row onto the ring
    lrow     = is_rd ? RW'(item_r.row) : cur_row_r;
    phys_sum = {1'b0, lrow} + {1'b0, top_r};
    phys_row = (int'(phys_sum) >= ROWS) ? RW'(phys_sum - (RW+1)'(ROWS)) : RW'(phys_sum);
    lcol     = cmd.fill ? fill_cnt_r : (is_rd ? CW'(item_r.col) : cell_col);
    addr     = AW'(phys_row) * AW'(COLS) + AW'(lcol);

    row_ready = row_vld_r[phys_row];
    wr_en     = cmd.fill || (cmd.exec && cell_write);
    rd_en     = cmd.exec && is_rd && read_ok && row_ready;
    wr_data   = (cmd.fill || is_bs) ? {color_r, tcw_pkg::CH_SP}
                                    : {color_r, item_r.char_code};
  end

  assign status.need_fill = cell_write && !row_ready;
  assign status.fill_last = fill_cnt_r == CW'(COLS - 1);
  assign status.out_free  = !out_valid_r || out_ready;

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr][7:0];
    end
  end

  // ---------------------------------------------------------------- cursor
  always_comb begin
    col_inc  = {1'b0, cur_col_r} + 1'b1;
    col_wrap = cell_write && !is_bs && int'(col_inc) >= COLS;
    row_adv  = is_nl || col_wrap;
    scroll   = is_wr && row_adv && cur_row_r == RW'(ROWS - 1);

    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    top_nxt      = top_r;
    row_vld_nxt  = row_vld_r;
    fill_cnt_nxt = fill_cnt_r;

    if (cmd.fill) begin
      fill_cnt_nxt = status.fill_last ? '0 : fill_cnt_r + 1'b1;
      if (status.fill_last) begin
        row_vld_nxt[phys_row] = 1'b1;
      end
    end

    if (cmd.exec) begin
      unique case (item_r.func)
        tcw_pkg::FUNC_WRITE: begin
          if (row_adv && !scroll) begin
            cur_row_nxt = cur_row_r + 1'b1;
          end
          if (is_nl || is_cr || col_wrap) begin
            cur_col_nxt = '0;
          end else if (is_bs) begin
            cur_col_nxt = bs_nop ? cur_col_r : cell_col;
          end else begin
            cur_col_nxt = CW'(col_inc);
          end
          // scroll: rotate the ring, old top row becomes the stale bottom row
          if (scroll) begin
            top_nxt = (int'(top_r) == ROWS - 1) ? '0 : top_r + 1'b1;
            row_vld_nxt[top_r] = 1'b0;
          end
        end
        tcw_pkg::FUNC_READ: begin
          cur_row_nxt = cur_row_r;
        end
        tcw_pkg::FUNC_SET: begin
          cur_row_nxt = row_ok ? RW'(item_r.row) : RW'(ROWS - 1);
          cur_col_nxt = col_ok ? CW'(item_r.col) : CW'(COLS - 1);
        end
        tcw_pkg::FUNC_CLEAR: begin
          cur_row_nxt = '0;
          cur_col_nxt = '0;
          row_vld_nxt = '0;
        end
        default: begin
          cur_row_nxt = cur_row_r;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- result
  always_comb begin
    lin_idx = AW'(cur_row_r) * AW'(COLS) + AW'(cur_col_r);
    if (read_mem_r) begin
      read_char = rd_data_r;
    end else if (read_blank_r) begin
      read_char = tcw_pkg::CH_SP;
    end else begin
      read_char = '0;
    end
    out_data_nxt.read_char      = read_char;
    out_data_nxt.cursor_row     = 5'(cur_row_r);
    out_data_nxt.cursor_col     = 7'(cur_col_r);
    out_data_nxt.position_write = pw_r;
    out_data_nxt.position_value = pw_r ? 11'(lin_idx) : '0;
    out_data_nxt.scrolled       = sc_r;

    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    if (cmd.out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      top_r        <= '0;
      row_vld_r    <= '0;
      fill_cnt_r   <= '0;
      color_r      <= tcw_pkg::COLOR_RESET;
      shown_r      <= 1'b1;
      read_mem_r   <= 1'b0;
      read_blank_r <= 1'b0;
      pw_r         <= 1'b0;
      sc_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      top_r       <= top_nxt;
      row_vld_r   <= row_vld_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.exec) begin
        read_mem_r   <= rd_en;
        read_blank_r <= is_rd && read_ok && !row_ready;
        pw_r         <= is_wr && !bs_nop && shown_r;
        sc_r         <= scroll;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          tcw_pkg::CFG_TEXT_COLOR:   color_r <= cfg_data;
          tcw_pkg::CFG_CURSOR_SHOWN: shown_r <= cfg_data[0];
          default:                   color_r <= color_r;
        endcase
      end
    end
  end

endmodule
